>>> hw/rtl/dvs_pkg.sv
// dvs_pkg: shared types and constants for the direction to velocity scaler
// used by every module under hw/rtl, no dependencies
`timescale 1ns / 1ps

package dvs_pkg;

    localparam int unsigned COMP_W   = 16;
    localparam int unsigned SPEED_W  = 7;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned QUO_W    = SPEED_W + FRAC_W;
    localparam int unsigned PROD_W   = COMP_W + QUO_W + 1;
    localparam int unsigned MAX_LEN  = 40960;
    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned M_DATA_W = 48;

    // one request travelling down the divider chain
    typedef struct packed {
        logic signed [COMP_W-1:0] dir_x;
        logic signed [COMP_W-1:0] dir_y;
        logic [LEN_W-1:0]         approx_length;
        logic [LEN_W-1:0]         divisor;
        logic [LEN_W-1:0]         rem;
        logic [QUO_W-1:0]         quo;
    } div_item_t;

    typedef struct packed {
        logic [LEN_W-1:0]         approx_length;
        logic signed [COMP_W-1:0] vel_y;
        logic signed [COMP_W-1:0] vel_x;
    } result_t;

endpackage

>>> hw/rtl/dvs_prep.sv
// dvs_prep: absolute values, alpha-max-plus-beta-min length and divider set-up
// depends on dvs_pkg
`timescale 1ns / 1ps

module dvs_prep (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [dvs_pkg::COMP_W-1:0]   dir_x,
    input  logic signed [dvs_pkg::COMP_W-1:0]   dir_y,
    input  logic [dvs_pkg::SPEED_W-1:0]         speed,
    output logic                                out_valid,
    input  logic                                out_ready,
    output dvs_pkg::div_item_t                  out_data
);

    logic                     valid_reg;
    logic                     valid_next;
    dvs_pkg::div_item_t       data_reg;
    dvs_pkg::div_item_t       data_next;
    logic [dvs_pkg::COMP_W:0] sx;
    logic [dvs_pkg::COMP_W:0] sy;
    logic [dvs_pkg::COMP_W:0] ax;
    logic [dvs_pkg::COMP_W:0] ay;
    logic [dvs_pkg::COMP_W:0] mx;
    logic [dvs_pkg::COMP_W:0] mn;
    logic [dvs_pkg::COMP_W:0] len_sum;
    logic [dvs_pkg::LEN_W-1:0] len;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        sx      = {dir_x[dvs_pkg::COMP_W-1], dir_x};
        sy      = {dir_y[dvs_pkg::COMP_W-1], dir_y};
        ax      = dir_x[dvs_pkg::COMP_W-1] ? (~sx + 1'b1) : sx;
        ay      = dir_y[dvs_pkg::COMP_W-1] ? (~sy + 1'b1) : sy;
        mx      = (ax > ay) ? ax : ay;
        mn      = (ax < ay) ? ax : ay;
        len_sum = mx + {2'b00, mn[dvs_pkg::COMP_W:2]};
        len     = len_sum[dvs_pkg::LEN_W-1:0];

        data_next.dir_x         = dir_x;
        data_next.dir_y         = dir_y;
        data_next.approx_length = len;
        data_next.divisor       = (len == '0) ? dvs_pkg::LEN_W'(1) : len;
        data_next.rem           = '0;
        data_next.quo           = {speed, {dvs_pkg::FRAC_W{1'b0}}};
        valid_next              = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hw/rtl/dvs_div_cell.sv
// dvs_div_cell: one restoring division step, one quotient bit per cell
// depends on dvs_pkg
`timescale 1ns / 1ps

module dvs_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dvs_pkg::div_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output dvs_pkg::div_item_t  out_data
);

    logic                      valid_reg;
    logic                      valid_next;
    dvs_pkg::div_item_t        data_reg;
    dvs_pkg::div_item_t        data_next;
    logic [dvs_pkg::LEN_W:0]   rem_sh;
    logic [dvs_pkg::LEN_W:0]   rem_sub;
    logic                      q_bit;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        rem_sh  = {in_data.rem, in_data.quo[dvs_pkg::QUO_W-1]};
        q_bit   = (rem_sh >= {1'b0, in_data.divisor});
        rem_sub = rem_sh - {1'b0, in_data.divisor};

        data_next     = in_data;
        data_next.rem = q_bit ? rem_sub[dvs_pkg::LEN_W-1:0] : rem_sh[dvs_pkg::LEN_W-1:0];
        data_next.quo = {in_data.quo[dvs_pkg::QUO_W-2:0], q_bit};
        valid_next    = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`ifndef ASSERT_OFF
    a_rem_below_divisor : assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.rem < data_reg.divisor))
        else $error("remainder not below divisor");

    a_divisor_from_length : assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((data_reg.approx_length == '0) ? (data_reg.divisor == 1)
                                                     : (data_reg.divisor == data_reg.approx_length)))
        else $error("divisor does not follow length");

    a_length_range : assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.approx_length <= dvs_pkg::LEN_W'(dvs_pkg::MAX_LEN)))
        else $error("length out of range");

    a_stall_keeps_request : assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(data_reg)))
        else $error("stalled request lost or changed");
`endif

endmodule

>>> hw/rtl/dvs_mul.sv
// dvs_mul: scales both components by the quotient and holds the result
// depends on dvs_pkg
`timescale 1ns / 1ps

module dvs_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dvs_pkg::div_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output dvs_pkg::result_t    out_data
);

    logic                              valid_reg;
    logic                              valid_next;
    logic signed [dvs_pkg::PROD_W-1:0] prod_x_reg;
    logic signed [dvs_pkg::PROD_W-1:0] prod_y_reg;
    logic signed [dvs_pkg::PROD_W-1:0] prod_x_next;
    logic signed [dvs_pkg::PROD_W-1:0] prod_y_next;
    logic [dvs_pkg::LEN_W-1:0]         len_reg;
    logic signed [dvs_pkg::QUO_W:0]    scale;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        scale       = $signed({1'b0, in_data.quo});
        prod_x_next = in_data.dir_x * scale;
        prod_y_next = in_data.dir_y * scale;
        valid_next  = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            len_reg    <= in_data.approx_length;
        end
    end

    // bits 31..16 of the wrapped product
    assign out_valid              = valid_reg;
    assign out_data.vel_x         = prod_x_reg[31:16];
    assign out_data.vel_y         = prod_y_reg[31:16];
    assign out_data.approx_length = len_reg;

endmodule

>>> hw/rtl/direction_to_velocity_scaler.sv
// path: an accepted request passes the registered length stage, 23 division cells
// and the multiply stage before m_tvalid, and waits longer only while the output is stalled
// throughput: one request per cycle while the output is not stalled, every stage has its own valid bit
// reset: rst_n clears all valid bits, payload registers are not reset
// direction_to_velocity_scaler: top level, chains prep, division cells and multiply
// depends on dvs_pkg, dvs_prep, dvs_div_cell, dvs_mul
`timescale 1ns / 1ps

module direction_to_velocity_scaler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dvs_pkg::S_DATA_W-1:0]  s_tdata,  // dir_x, dir_y, speed, zero pad
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dvs_pkg::M_DATA_W-1:0]  m_tdata   // vel_x, vel_y, approx_length
);

    logic               cell_valid [dvs_pkg::QUO_W+1];
    logic               cell_ready [dvs_pkg::QUO_W+1];
    dvs_pkg::div_item_t cell_data  [dvs_pkg::QUO_W+1];
    dvs_pkg::result_t   result;

    dvs_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .dir_x     (s_tdata[15:0]),
        .dir_y     (s_tdata[31:16]),
        .speed     (s_tdata[38:32]),
        .out_valid (cell_valid[0]),
        .out_ready (cell_ready[0]),
        .out_data  (cell_data[0])
    );

    for (genvar i = 0; i < dvs_pkg::QUO_W; i++)
    begin : g_cell
        dvs_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cell_valid[i]),
            .in_ready  (cell_ready[i]),
            .in_data   (cell_data[i]),
            .out_valid (cell_valid[i+1]),
            .out_ready (cell_ready[i+1]),
            .out_data  (cell_data[i+1])
        );
    end

    dvs_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cell_valid[dvs_pkg::QUO_W]),
        .in_ready  (cell_ready[dvs_pkg::QUO_W]),
        .in_data   (cell_data[dvs_pkg::QUO_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    assign m_tdata = result;

endmodule
